// ===== design/ljsf_pkg.sv =====
// Package for the Lennard-Jones shifted-force pair block.
// Holds shared widths, register codes, payload structs and the UQ32.32 multiply helpers.
// Depends on nothing; every design module imports it, while the two interfaces do not.
package ljsf_pkg;

   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CMAG_W    = 48;
   localparam int ACC_W     = 51;
   localparam int QDIV_W    = 65;
   localparam int WDIV_W    = 80;

   localparam logic [31:0] SIGMA_RST  = 32'd65536;
   localparam logic [31:0] EPS_RST    = 32'd65536;
   localparam logic [31:0] CUTOFF_RST = 32'd163840;
   localparam logic [30:0] BOX_RST    = 31'd983040;

   localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] INT_MIN = 32'h8000_0000;
   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGMA  = 3'd0,
      CSR_EPS    = 3'd1,
      CSR_FSHIFT = 3'd2,
      CSR_ESHIFT = 3'd3,
      CSR_CUTOFF = 3'd4,
      CSR_BOX    = 3'd5
   } ljsf_csr_type;

   typedef struct packed {
      logic              zero;
      logic              dneg;
      logic              cneg;
      logic [CMAG_W-1:0] cmag;
   } ljsf_flag_type;

   typedef struct packed {
      ljsf_flag_type flg;
      logic [32:0]   dm;
      logic [31:0]   r;
   } ljsf_front_type;

   typedef struct packed {
      ljsf_flag_type flg;
      logic [63:0]   q;
      logic [63:0]   u;
   } ljsf_mid_type;

   typedef struct packed {
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } ljsf_pp_type;

   typedef struct packed {
      logic signed [31:0] force_component;
      logic signed [31:0] pair_energy;
      logic               zero_distance;
      logic               saturated;
   } ljsf_rsp_type;

   // Four 32x32 partial products of a 64x64 UQ32.32 multiply.
   function automatic ljsf_pp_type pp_mul(input logic [63:0] a, input logic [63:0] b);
      ljsf_pp_type pp;
      pp.p00 = 64'(a[31:0]) * 64'(b[31:0]);
      pp.p01 = 64'(a[31:0]) * 64'(b[63:32]);
      pp.p10 = 64'(a[63:32]) * 64'(b[31:0]);
      pp.p11 = 64'(a[63:32]) * 64'(b[63:32]);
      return pp;
   endfunction

   // Combines partial products into the truncated UQ32.32 result, clipped to all ones.
   function automatic logic [63:0] pp_sum(input ljsf_pp_type pp);
      logic [33:0] mid;
      logic [65:0] hi;
      mid = 34'(pp.p00[63:32]) + 34'(pp.p01[31:0]) + 34'(pp.p10[31:0]);
      hi  = 66'(pp.p11) + 66'(pp.p01[63:32]) + 66'(pp.p10[63:32]) + 66'(mid[33:32]);
      if (hi[65:32] != 34'd0) begin
         return '1;
      end
      return {hi[31:0], mid[31:0]};
   endfunction

endpackage

// ===== design/ljsf_req_if.sv =====
// Request channel of the pair block: valid/ready handshake and the pair operands.
// Standalone interface; no package needed.
interface ljsf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] coord_self;
   logic signed [31:0] coord_other;
   logic        [31:0] pair_distance;

   modport source (output valid, output coord_self, output coord_other,
                   output pair_distance, input ready);
   modport sink   (input valid, input coord_self, input coord_other,
                   input pair_distance, output ready);
endinterface

// ===== design/ljsf_rsp_if.sv =====
// Response channel of the pair block: valid/ready handshake and force, energy and flags.
// Standalone interface; no package needed.
interface ljsf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_component;
   logic signed [31:0] pair_energy;
   logic               zero_distance;
   logic               saturated;

   modport source (output valid, output force_component, output pair_energy,
                   output zero_distance, output saturated, input ready);
   modport sink   (input valid, input force_component, input pair_energy,
                   input zero_distance, input saturated, output ready);
endinterface

// ===== design/lj_shifted_force_pair.sv =====
// Lennard-Jones shifted-force pair unit, one axis, signed Q16.16 fixed point.
// Uses ljsf_pkg, ljsf_req_if, ljsf_rsp_if, ljsf_front, ljsf_div and ljsf_mul.
//
// One pair is accepted every clock cycle unless the skid entry is full, and each pair passes
// through 3 front stages, a 65-stage divider for sigma/r and |d|/r, an 80-stage
// divider for |d|/r^2 (one quotient bit per stage sets most of the depth), 13 multiply
// stages and the output register. A one-entry skid buffer behind the output register
// takes the result that is in flight when the consumer stalls; once both are full
// the whole pipeline holds. Configuration registers may be written only when no pair is
// in flight. A zero pair distance returns zero force and energy with zero_distance set.
module lj_shifted_force_pair import ljsf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ljsf_req_if.sink             req_ch,
   ljsf_rsp_if.source           rsp_ch,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   logic [31:0] sigma_ff, eps_ff, cutoff_ff;
   logic signed [31:0] fshift_ff, eshift_ff;
   logic [30:0] box_ff;

   logic adv;
   logic [31:0] fs_mag;

   logic           fr_v;
   ljsf_front_type fr_d;

   logic                         d1_v;
   logic [DATA_W-1:0]            d1_den;
   logic [1:0][QDIV_W-1:0]       d1_num, d1_quo;
   logic [$bits(ljsf_flag_type)-1:0] d1_side;
   ljsf_flag_type                d1_flg;
   logic [63:0]                  u_clip;
   ljsf_mid_type                 mid_in;

   logic                         d2_v;
   logic [DATA_W-1:0]            d2_den;
   logic [0:0][WDIV_W-1:0]       d2_num, d2_quo;
   logic [$bits(ljsf_mid_type)-1:0] d2_side;
   ljsf_mid_type                 mid_out;
   logic [63:0]                  w_clip;

   logic                    mu_v, mu_zero;
   logic signed [ACC_W-1:0] mu_force, mu_energy;

   ljsf_rsp_type pipe_rsp, out_ff, skid_ff;
   logic         out_v_ff, skid_v_ff, take;
   logic         clip_f, clip_e;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff  <= SIGMA_RST;
         eps_ff    <= EPS_RST;
         fshift_ff <= '0;
         eshift_ff <= '0;
         cutoff_ff <= CUTOFF_RST;
         box_ff    <= BOX_RST;
      end else if (csr_write) begin
         case (ljsf_csr_type'(csr_index))
            CSR_SIGMA:  sigma_ff  <= csr_wdata;
            CSR_EPS:    eps_ff    <= csr_wdata;
            CSR_FSHIFT: fshift_ff <= $signed(csr_wdata);
            CSR_ESHIFT: eshift_ff <= $signed(csr_wdata);
            CSR_CUTOFF: cutoff_ff <= csr_wdata;
            CSR_BOX:    box_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign fs_mag = fshift_ff[31] ? (~fshift_ff + 32'd1) : fshift_ff;

   // The pipeline moves whenever the skid entry is free.
   assign adv          = ~skid_v_ff;
   assign req_ch.ready = adv;

   ljsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_ch.valid),
      .in_self   (req_ch.coord_self),
      .in_other  (req_ch.coord_other),
      .in_r      (req_ch.pair_distance),
      .box       (box_ff),
      .cutoff    (cutoff_ff),
      .fs_mag    (fs_mag),
      .fs_neg    (fshift_ff[31]),
      .out_valid (fr_v),
      .out_data  (fr_d)
   );

   assign d1_num[0] = {1'b0, sigma_ff, 32'b0};
   assign d1_num[1] = {fr_d.dm, 32'b0};

   ljsf_div #(
      .QW     (QDIV_W),
      .LANES  (2),
      .SIDE_W ($bits(ljsf_flag_type))
   ) u_div_qu (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (fr_v),
      .in_den    (fr_d.r),
      .in_num    (d1_num),
      .in_side   (fr_d.flg),
      .out_valid (d1_v),
      .out_den   (d1_den),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   assign d1_flg     = d1_side;
   assign u_clip     = d1_quo[1][QDIV_W-1] ? '1 : d1_quo[1][63:0];
   assign mid_in.flg = d1_flg;
   assign mid_in.q   = d1_quo[0][63:0];
   assign mid_in.u   = u_clip;
   assign d2_num[0]  = {u_clip, 16'b0};

   ljsf_div #(
      .QW     (WDIV_W),
      .LANES  (1),
      .SIDE_W ($bits(ljsf_mid_type))
   ) u_div_w (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d1_v),
      .in_den    (d1_den),
      .in_num    (d2_num),
      .in_side   (mid_in),
      .out_valid (d2_v),
      .out_den   (d2_den),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   assign mid_out = d2_side;
   assign w_clip  = (d2_quo[0][WDIV_W-1:64] != '0) ? '1 : d2_quo[0][63:0];

   ljsf_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (d2_v),
      .in_mid     (mid_out),
      .in_w       ((d2_den != '0) ? w_clip : w_clip),
      .eps        (eps_ff),
      .fs_mag     (fs_mag),
      .fs_neg     (fshift_ff[31]),
      .es         (eshift_ff),
      .out_valid  (mu_v),
      .out_zero   (mu_zero),
      .out_force  (mu_force),
      .out_energy (mu_energy)
   );

   // Saturation to the Q16.16 range and the zero-distance override.
   always_comb begin
      clip_f = (mu_force[ACC_W-1:31] != {(ACC_W-31){mu_force[ACC_W-1]}});
      clip_e = (mu_energy[ACC_W-1:31] != {(ACC_W-31){mu_energy[ACC_W-1]}});
      if (mu_zero) begin
         pipe_rsp.force_component = '0;
         pipe_rsp.pair_energy     = '0;
         pipe_rsp.zero_distance   = 1'b1;
         pipe_rsp.saturated       = 1'b0;
      end else begin
         if (clip_f) begin
            pipe_rsp.force_component = mu_force[ACC_W-1] ? INT_MIN : INT_MAX;
         end else begin
            pipe_rsp.force_component = mu_force[31:0];
         end
         if (clip_e) begin
            pipe_rsp.pair_energy = mu_energy[ACC_W-1] ? INT_MIN : INT_MAX;
         end else begin
            pipe_rsp.pair_energy = mu_energy[31:0];
         end
         pipe_rsp.zero_distance = 1'b0;
         pipe_rsp.saturated     = clip_f | clip_e;
      end
   end

   assign take = rsp_ch.ready | ~out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= mu_v;
         end
      end else if (adv && mu_v) begin
         skid_v_ff <= 1'b1;
      end
      if (take) begin
         out_ff <= skid_v_ff ? skid_ff : pipe_rsp;
      end
      if (!take && adv) begin
         skid_ff <= pipe_rsp;
      end
   end

   assign rsp_ch.valid           = out_v_ff;
   assign rsp_ch.force_component = out_ff.force_component;
   assign rsp_ch.pair_energy     = out_ff.pair_energy;
   assign rsp_ch.zero_distance   = out_ff.zero_distance;
   assign rsp_ch.saturated       = out_ff.saturated;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ch.ready))
      else $error("skid entry filled without a stalled output");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.zero_distance) |->
         (rsp_ch.force_component == 32'sd0 && rsp_ch.pair_energy == 32'sd0
          && !rsp_ch.saturated))
      else $error("zero-distance result carries nonzero values");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
         (rsp_ch.force_component == INT_MAX || rsp_ch.force_component == INT_MIN
          || rsp_ch.pair_energy == INT_MAX || rsp_ch.pair_energy == INT_MIN))
      else $error("saturated result has no value at a range limit");

endmodule

// ===== design/ljsf_front.sv =====
// Front stages: coordinate difference, minimum-image wrap, magnitudes and the cutoff term.
// Three register stages; uses ljsf_pkg.
module ljsf_front import ljsf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] in_self,
   input  logic signed [31:0] in_other,
   input  logic        [31:0] in_r,
   input  logic        [30:0] box,
   input  logic        [31:0] cutoff,
   input  logic        [31:0] fs_mag,
   input  logic               fs_neg,
   output logic               out_valid,
   output ljsf_front_type     out_data
);

   logic               v0_ff, v1_ff, v2_ff;
   logic signed [33:0] diff_ff;
   logic signed [32:0] rd_ff;
   logic        [31:0] r0_ff, r1_ff, r2_ff;
   logic               z0_ff, z1_ff, z2_ff;
   logic signed [33:0] d_ff;
   logic        [31:0] rdmag_ff;
   logic               cneg1_ff, cneg2_ff;
   logic               dneg_ff;
   logic        [32:0] dm_ff;
   logic        [63:0] cprod_ff;

   logic signed [33:0] diff_in;
   logic signed [32:0] rd_in;
   logic signed [34:0] boxs, dbl, dsub, dadd;
   logic signed [33:0] d_in;
   logic signed [32:0] rd_neg;
   logic signed [33:0] d_neg;

   assign diff_in = 34'(in_self) - 34'(in_other);
   assign rd_in   = $signed({1'b0, in_r}) - $signed({1'b0, cutoff});

   // A single wrap by the box edge, chosen by comparing twice the difference.
   always_comb begin
      boxs = $signed({4'b0, box});
      dbl  = 35'(diff_ff) <<< 1;
      dsub = 35'(diff_ff) - boxs;
      dadd = 35'(diff_ff) + boxs;
      if (dbl > boxs) begin
         d_in = $signed(dsub[33:0]);
      end else if (dbl < -boxs) begin
         d_in = $signed(dadd[33:0]);
      end else begin
         d_in = diff_ff;
      end
      rd_neg = -rd_ff;
      d_neg  = -d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      if (en) begin
         diff_ff  <= diff_in;
         rd_ff    <= rd_in;
         r0_ff    <= in_r;
         z0_ff    <= (in_r == 32'd0);
         d_ff     <= d_in;
         rdmag_ff <= rd_ff[32] ? rd_neg[31:0] : rd_ff[31:0];
         cneg1_ff <= rd_ff[32] ^ fs_neg;
         r1_ff    <= r0_ff;
         z1_ff    <= z0_ff;
         dneg_ff  <= d_ff[33];
         dm_ff    <= d_ff[33] ? d_neg[32:0] : d_ff[32:0];
         cprod_ff <= 64'(rdmag_ff) * 64'(fs_mag);
         cneg2_ff <= cneg1_ff;
         r2_ff    <= r1_ff;
         z2_ff    <= z1_ff;
      end
   end

   assign out_valid         = v2_ff;
   assign out_data.flg.zero = z2_ff;
   assign out_data.flg.dneg = dneg_ff;
   assign out_data.flg.cneg = cneg2_ff;
   assign out_data.flg.cmag = cprod_ff[63:16];
   assign out_data.dm       = dm_ff;
   assign out_data.r        = r2_ff;

endmodule

// ===== design/ljsf_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, one or more numerators per divisor.
// A side payload travels with each item; uses ljsf_pkg for the divisor width.
module ljsf_div import ljsf_pkg::*; #(
   parameter int QW     = 65,
   parameter int LANES  = 2,
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [DATA_W-1:0]            in_den,
   input  logic [LANES-1:0][QW-1:0]     in_num,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [DATA_W-1:0]            out_den,
   output logic [LANES-1:0][QW-1:0]     out_quo,
   output logic [SIDE_W-1:0]            out_side
);

   logic                           v_ff    [QW];
   logic                           v_in    [QW];
   logic [DATA_W-1:0]              den_ff  [QW];
   logic [DATA_W-1:0]              den_in  [QW];
   logic [LANES-1:0][QW-1:0]       num_ff  [QW];
   logic [LANES-1:0][QW-1:0]       num_in  [QW];
   logic [LANES-1:0][QW-1:0]       quo_ff  [QW];
   logic [LANES-1:0][QW-1:0]       quo_in  [QW];
   logic [LANES-1:0][DATA_W-1:0]   rem_ff  [QW];
   logic [LANES-1:0][DATA_W-1:0]   rem_in  [QW];
   logic [SIDE_W-1:0]              side_ff [QW];
   logic [SIDE_W-1:0]              side_in [QW];

   always_comb begin
      logic                         pv;
      logic [DATA_W-1:0]            pden;
      logic [LANES-1:0][QW-1:0]     pnum, pquo;
      logic [LANES-1:0][DATA_W-1:0] prem;
      logic [SIDE_W-1:0]            pside;
      logic [DATA_W:0]              cat;
      logic [DATA_W+1:0]            dif;
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            pv    = in_valid;
            pden  = in_den;
            pnum  = in_num;
            pquo  = '0;
            prem  = '0;
            pside = in_side;
         end else begin
            pv    = v_ff[k-1];
            pden  = den_ff[k-1];
            pnum  = num_ff[k-1];
            pquo  = quo_ff[k-1];
            prem  = rem_ff[k-1];
            pside = side_ff[k-1];
         end
         v_in[k]    = pv;
         den_in[k]  = pden;
         side_in[k] = pside;
         for (int l = 0; l < LANES; l++) begin
            cat = {prem[l], pnum[l][QW-1]};
            dif = {1'b0, cat} - {2'b0, pden};
            // A clear top bit means the trial subtract fits: quotient bit is one.
            rem_in[k][l] = dif[DATA_W+1] ? cat[DATA_W-1:0] : dif[DATA_W-1:0];
            quo_in[k][l] = {pquo[l][QW-2:0], ~dif[DATA_W+1]};
            num_in[k][l] = {pnum[l][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_in[k];
         end
         if (en) begin
            den_ff[k]  <= den_in[k];
            num_ff[k]  <= num_in[k];
            quo_ff[k]  <= quo_in[k];
            rem_ff[k]  <= rem_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_den   = den_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ===== design/ljsf_mul.sv =====
// Multiply pipeline: powers of sigma/r, energy and force terms, and the final signed sums.
// Each 64x64 product takes one stage of partial products and one stage of summing.
module ljsf_mul import ljsf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  ljsf_mid_type            in_mid,
   input  logic [63:0]             in_w,
   input  logic [31:0]             eps,
   input  logic [31:0]             fs_mag,
   input  logic                    fs_neg,
   input  logic signed [31:0]      es,
   output logic                    out_valid,
   output logic                    out_zero,
   output logic signed [ACC_W-1:0] out_force,
   output logic signed [ACC_W-1:0] out_energy
);

   localparam int NST = 13;

   logic          v_ff     [NST];
   logic          v_in     [NST];
   ljsf_flag_type flg_ff   [NST];
   ljsf_flag_type flg_in   [NST];
   logic [63:0]   u_ff     [NST];
   logic [63:0]   u_in     [NST];
   logic [63:0]   w_ff     [NST];
   logic [63:0]   w_in     [NST];
   logic          s6ge_ff  [NST];
   logic          s6ge_in  [NST];
   logic          twoge_ff [NST];
   logic          twoge_in [NST];
   logic [47:0]   t2_ff    [NST];
   logic [47:0]   t2_in    [NST];
   logic [47:0]   amag_ff  [NST];
   logic [47:0]   amag_in  [NST];

   ljsf_pp_type pq_ff, pp4_ff, ps6_ff, pa1_ff, pb1_ff, pt2_ff, pam_ff, pbm_ff, pb3_ff;
   logic [63:0] p2_ff, p2b_ff, p2c_ff, p4_ff, s6_ff;
   logic [63:0] m_ff, m2_ff, mb_ff, m2b_ff, a1_ff, b1_ff, b2_ff;
   logic [47:0] t1_ff;
   logic signed [ACC_W-1:0] force_ff, energy_ff;

   logic [63:0] eps32, eps6, fs64;
   logic [34:0] eps_x6;
   logic        s6ge, twoge;
   logic [63:0] m_v, m2_v, s6x2;
   logic [63:0] t2_full, a2_full, b3_full;
   logic signed [ACC_W-1:0] t1s, t2s, as_v, cs_v, force_v, energy_v;
   logic        neg1, neg2;

   assign eps_x6 = {1'b0, eps, 2'b0} + {2'b0, eps, 1'b0};
   assign eps32  = {16'b0, eps, 16'b0};
   assign eps6   = {13'b0, eps_x6, 16'b0};
   assign fs64   = {16'b0, fs_mag, 16'b0};

   // Distance factors |s6-1| and |2*s6-1|; the latter clips when 2*s6 overflows.
   always_comb begin
      s6ge = (s6_ff[63:32] != 32'd0);
      twoge = (s6_ff[63:31] != 33'd0);
      s6x2 = {s6_ff[62:0], 1'b0};
      m_v  = s6ge ? s6_ff - ONE_Q32 : ONE_Q32 - s6_ff;
      if (s6_ff[63]) begin
         m2_v = '1;
      end else begin
         m2_v = twoge ? s6x2 - ONE_Q32 : ONE_Q32 - s6x2;
      end
   end

   assign t2_full = pp_sum(pt2_ff);
   assign a2_full = pp_sum(pam_ff);
   assign b3_full = pp_sum(pb3_ff);

   always_comb begin
      for (int k = 0; k < NST; k++) begin
         if (k == 0) begin
            v_in[k]     = in_valid;
            flg_in[k]   = in_mid.flg;
            u_in[k]     = in_mid.u;
            w_in[k]     = in_w;
            s6ge_in[k]  = 1'b0;
            twoge_in[k] = 1'b0;
            t2_in[k]    = '0;
            amag_in[k]  = '0;
         end else begin
            v_in[k]     = v_ff[k-1];
            flg_in[k]   = flg_ff[k-1];
            u_in[k]     = u_ff[k-1];
            w_in[k]     = w_ff[k-1];
            s6ge_in[k]  = s6ge_ff[k-1];
            twoge_in[k] = twoge_ff[k-1];
            t2_in[k]    = t2_ff[k-1];
            amag_in[k]  = amag_ff[k-1];
         end
      end
      s6ge_in[6]  = s6ge;
      twoge_in[6] = twoge;
      t2_in[7]    = t2_full[63:16];
      amag_in[9]  = a2_full[63:16];
   end

   // Final signed sums; every magnitude is below 2^48, so ACC_W bits hold them exactly.
   always_comb begin
      t1s  = $signed(ACC_W'(t1_ff));
      t2s  = $signed(ACC_W'(t2_ff[11]));
      as_v = $signed(ACC_W'(amag_ff[11]));
      cs_v = $signed(ACC_W'(flg_ff[11].cmag));
      neg1 = flg_ff[11].dneg ^ ~twoge_ff[11];
      neg2 = flg_ff[11].dneg ^ fs_neg;
      force_v  = (neg1 ? -t1s : t1s) - (neg2 ? -t2s : t2s);
      energy_v = (s6ge_ff[11] ? as_v : -as_v) - ACC_W'(es)
                 + (flg_ff[11].cneg ? -cs_v : cs_v);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_in[k];
         end
         if (en) begin
            flg_ff[k]   <= flg_in[k];
            u_ff[k]     <= u_in[k];
            w_ff[k]     <= w_in[k];
            s6ge_ff[k]  <= s6ge_in[k];
            twoge_ff[k] <= twoge_in[k];
            t2_ff[k]    <= t2_in[k];
            amag_ff[k]  <= amag_in[k];
         end
      end
      if (en) begin
         pq_ff     <= pp_mul(in_mid.q, in_mid.q);
         p2_ff     <= pp_sum(pq_ff);
         pp4_ff    <= pp_mul(p2_ff, p2_ff);
         p2b_ff    <= p2_ff;
         p4_ff     <= pp_sum(pp4_ff);
         p2c_ff    <= p2b_ff;
         ps6_ff    <= pp_mul(p4_ff, p2c_ff);
         s6_ff     <= pp_sum(ps6_ff);
         pa1_ff    <= pp_mul(eps32, s6_ff);
         pb1_ff    <= pp_mul(eps6, s6_ff);
         pt2_ff    <= pp_mul(fs64, u_ff[5]);
         m_ff      <= m_v;
         m2_ff     <= m2_v;
         a1_ff     <= pp_sum(pa1_ff);
         b1_ff     <= pp_sum(pb1_ff);
         mb_ff     <= m_ff;
         m2b_ff    <= m2_ff;
         pam_ff    <= pp_mul(a1_ff, mb_ff);
         pbm_ff    <= pp_mul(b1_ff, m2b_ff);
         b2_ff     <= pp_sum(pbm_ff);
         pb3_ff    <= pp_mul(b2_ff, w_ff[9]);
         t1_ff     <= b3_full[63:16];
         force_ff  <= force_v;
         energy_ff <= energy_v;
      end
   end

   assign out_valid  = v_ff[NST-1];
   assign out_zero   = flg_ff[NST-1].zero;
   assign out_force  = force_ff;
   assign out_energy = energy_ff;

endmodule
